@@ hdl/dpc_pkg.sv @@
package dpc_pkg;

   localparam int unsigned DIST_W   = 16;
   localparam int unsigned GAIN_W   = 16;
   localparam int unsigned LIMIT_W  = 15;
   localparam int unsigned ERR_W    = 8;
   localparam int unsigned DELTA_W  = 9;
   localparam int unsigned PROD_W   = GAIN_W + DELTA_W;
   localparam int unsigned OUT_W    = 16;

   localparam logic [DIST_W-1:0]         FAR_LIMIT      = 16'd2500;
   localparam logic [DIST_W-1:0]         FAR_SUBSTITUTE = 16'd1500;
   localparam logic signed [DIST_W:0]    DEADBAND       = 17'sd5;
   localparam logic signed [ERR_W-1:0]   ERROR_CLAMP    = 8'sd100;
   localparam logic signed [ERR_W-1:0]   SUM_CLAMP      = 8'sd100;
   localparam logic [LIMIT_W-1:0]        DEFAULT_OUTPUT_LIMIT = 15'd1000;

   typedef enum logic [1:0] {
      CSR_GAIN_P     = 2'd0,
      CSR_GAIN_I     = 2'd1,
      CSR_GAIN_D     = 2'd2,
      CSR_OUT_LIMIT  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [ERR_W-1:0]   err;
      logic signed [ERR_W-1:0]   error_sum;
      logic signed [DELTA_W-1:0] delta;
   } err_terms_type;

   typedef struct packed {
      logic signed [GAIN_W+ERR_W-1:0] p_term;
      logic signed [GAIN_W+ERR_W-1:0] i_term;
      logic signed [PROD_W-1:0]       d_term;
   } products_type;

endpackage

@@ hdl/dpc_if.sv @@
interface dpc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] target_distance;
   logic [15:0] measured_distance;

   modport source (output valid, output target_distance, output measured_distance,
                   input ready);
   modport sink   (input valid, input target_distance, input measured_distance,
                   output ready);
endinterface

interface dpc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] drive_correction;

   modport source (output valid, output drive_correction, input ready);
   modport sink   (input valid, input drive_correction, output ready);
endinterface

@@ hdl/dpc_error_stage.sv @@
module dpc_error_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic [15:0]            target,
   input  logic [15:0]            measured,
   output dpc_pkg::err_terms_type terms
);
   import dpc_pkg::*;

   logic [DIST_W-1:0]         meas_fill;
   logic [DIST_W-1:0]         meas_used;
   logic signed [DIST_W:0]    diff;
   logic signed [ERR_W-1:0]   err;
   logic signed [ERR_W:0]     acc_wide;
   logic signed [ERR_W-1:0]   error_sum_ff;
   logic signed [ERR_W-1:0]   error_sum_in;
   logic signed [ERR_W-1:0]   previous_error_ff;

   always_comb begin
      meas_fill = (measured == '0) ? target : measured;
      meas_used = (meas_fill > FAR_LIMIT) ? FAR_SUBSTITUTE : meas_fill;
      diff      = $signed({1'b0, target}) - $signed({1'b0, meas_used});

      // deadband, then clamp
      priority if (diff > -DEADBAND && diff < DEADBAND) begin
         err = '0;
      end else if (diff > (DIST_W+1)'(ERROR_CLAMP)) begin
         err = ERROR_CLAMP;
      end else if (diff < -((DIST_W+1)'(ERROR_CLAMP))) begin
         err = -ERROR_CLAMP;
      end else begin
         err = diff[ERR_W-1:0];
      end

      acc_wide = (ERR_W+1)'(error_sum_ff) + (ERR_W+1)'(err);
      priority if (acc_wide > (ERR_W+1)'(SUM_CLAMP)) begin
         error_sum_in = SUM_CLAMP;
      end else if (acc_wide < -((ERR_W+1)'(SUM_CLAMP))) begin
         error_sum_in = -SUM_CLAMP;
      end else begin
         error_sum_in = acc_wide[ERR_W-1:0];
      end

      terms.err       = err;
      terms.error_sum = error_sum_in;
      terms.delta     = DELTA_W'(err) - DELTA_W'(previous_error_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff      <= '0;
         previous_error_ff <= '0;
      end else if (load) begin
         error_sum_ff      <= error_sum_in;
         previous_error_ff <= err;
      end
   end

endmodule

@@ hdl/dpc_output_stage.sv @@
module dpc_output_stage (
   input  dpc_pkg::products_type   products,
   input  logic [14:0]             limit,
   output logic signed [15:0]      correction
);
   import dpc_pkg::*;

   localparam int unsigned SUM_W = PROD_W + 2;
   localparam int unsigned SHR_W = SUM_W - 8;

   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] sum_biased;
   logic signed [SHR_W-1:0] scaled;
   logic signed [OUT_W-1:0] sat;
   logic [OUT_W:0]          mag;
   logic signed [OUT_W-1:0] val;

   always_comb begin
      sum = SUM_W'($signed(products.p_term)) + SUM_W'($signed(products.i_term))
          + SUM_W'($signed(products.d_term));
      // divide by 256, rounding toward zero
      sum_biased = sum[SUM_W-1] ? (sum + SUM_W'(255)) : sum;
      scaled     = sum_biased[SUM_W-1:8];

      priority if (scaled > SHR_W'(32767)) begin
         sat = 16'sh7FFF;
      end else if (scaled < -(SHR_W'(32768))) begin
         sat = 16'sh8000;
      end else begin
         sat = scaled[OUT_W-1:0];
      end

      mag = sat[OUT_W-1] ? ((OUT_W+1)'(0) - (OUT_W+1)'(sat)) : (OUT_W+1)'(sat);
      if (mag >= (OUT_W+1)'(limit)) begin
         val = (sat > 0) ? $signed({1'b0, limit}) : -$signed({1'b0, limit});
      end else begin
         val = sat;
      end

      correction = -val;
   end

endmodule

@@ hdl/distance_pid_controller_unit.sv @@
// Distance PID controller: four register stages, one word in per cycle.
// A word accepted passes through stages A, B, C and D in turn; its result is registered in stage D.
// Throughput: one word per cycle while the result side keeps up.
// Reset (synchronous, active high) empties the pipe, clears the integral
// and last error, sets gains to 0 and the output limit to 1000.
module distance_pid_controller_unit (
   input  logic                   clock,
   input  logic                   reset,
   dpc_req_if.sink                req_bus,
   dpc_rsp_if.source              rsp_bus,
   input  logic                   csr_write_enable,
   input  dpc_pkg::csr_index_type csr_index,
   input  logic [15:0]            csr_write_data
);
   import dpc_pkg::*;

   // Stage A: input register. Stage B: error terms (state updates here).
   // Stage C: the three gain products. Stage D: scale, clamp, negate.

   // configuration registers
   logic signed [GAIN_W-1:0] gain_p_ff;
   logic signed [GAIN_W-1:0] gain_i_ff;
   logic signed [GAIN_W-1:0] gain_d_ff;
   logic [LIMIT_W-1:0]       out_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         out_limit_ff <= DEFAULT_OUTPUT_LIMIT;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_GAIN_P:    gain_p_ff    <= csr_write_data;
            CSR_GAIN_I:    gain_i_ff    <= csr_write_data;
            CSR_GAIN_D:    gain_d_ff    <= csr_write_data;
            CSR_OUT_LIMIT: out_limit_ff <= csr_write_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline valids and the ready chain; each stage takes a word when it
   // is empty or its own word moves on in the same cycle
   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   logic a_ready, b_ready, c_ready, d_ready;
   logic a_load, b_load, c_load, d_load;

   assign d_ready = !d_valid_ff || rsp_bus.ready;
   assign c_ready = !c_valid_ff || d_ready;
   assign b_ready = !b_valid_ff || c_ready;
   assign a_ready = !a_valid_ff || b_ready;

   assign req_bus.ready = a_ready;
   assign a_load = req_bus.valid && a_ready;
   assign b_load = a_valid_ff && b_ready;
   assign c_load = b_valid_ff && c_ready;
   assign d_load = c_valid_ff && d_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= req_bus.valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
         if (c_ready) c_valid_ff <= b_valid_ff;
         if (d_ready) d_valid_ff <= c_valid_ff;
      end
   end

   // stage A
   logic [DIST_W-1:0] target_ff;
   logic [DIST_W-1:0] measured_ff;

   always_ff @(posedge clock) begin
      if (a_load) begin
         target_ff   <= req_bus.target_distance;
         measured_ff <= req_bus.measured_distance;
      end
   end

   // stage B: error, clamped integral and derivative; the integral and the
   // last error commit only when the word moves into this stage
   err_terms_type terms_in;
   err_terms_type terms_ff;

   dpc_error_stage u_error (
      .clock    (clock),
      .reset    (reset),
      .load     (b_load),
      .target   (target_ff),
      .measured (measured_ff),
      .terms    (terms_in)
   );

   always_ff @(posedge clock) begin
      if (b_load) terms_ff <= terms_in;
   end

   // stage C: three independent signed products
   products_type products_in;
   products_type products_ff;

   always_comb begin
      products_in.p_term = (GAIN_W+ERR_W)'(gain_p_ff)
                         * (GAIN_W+ERR_W)'($signed(terms_ff.err));
      products_in.i_term = (GAIN_W+ERR_W)'(gain_i_ff)
                         * (GAIN_W+ERR_W)'($signed(terms_ff.error_sum));
      products_in.d_term = PROD_W'(gain_d_ff) * PROD_W'($signed(terms_ff.delta));
   end

   always_ff @(posedge clock) begin
      if (c_load) products_ff <= products_in;
   end

   // stage D: sum, Q8.8 scaling, saturation, limit, negation
   logic signed [OUT_W-1:0] correction_in;
   logic signed [OUT_W-1:0] correction_ff;

   dpc_output_stage u_output (
      .products   (products_ff),
      .limit      (out_limit_ff),
      .correction (correction_in)
   );

   always_ff @(posedge clock) begin
      if (d_load) correction_ff <= correction_in;
   end

   assign rsp_bus.valid            = d_valid_ff;
   assign rsp_bus.drive_correction = correction_ff;

endmodule
